// File: src/sobel_gradient_replicate_edge_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel gradient block
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_REPLICATE_EDGE_TOP_ASSERT_SVH
`define SOBEL_GRADIENT_REPLICATE_EDGE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SGRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SGRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sgre_pkg.sv
// ----------------------------------------------------------------------------
// sgre_pkg
// Widths, reset values, register indexes and shared types of the Sobel block.
// ----------------------------------------------------------------------------
package sgre_pkg;

  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 9;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int ROW_LIMIT     = 4096;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][PIX_W-1:0] trio_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             row_ge1;
    logic             row_ge2;
    logic             row_last;
    logic             col_ge1;
    logic             col_ge2;
    logic             col_last;
  } pos_t;

  typedef struct packed {
    pix_t pixel;
    pix_t older;
    pix_t newer;
    pos_t pos;
  } col_item_t;

endpackage

// File: src/sgre_pixel_if.sv
// ----------------------------------------------------------------------------
// sgre_pixel_if
// Valid/ready channel carrying one gray pixel per request.
// ----------------------------------------------------------------------------
interface sgre_pixel_if import sgre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: src/sgre_grad_if.sv
// ----------------------------------------------------------------------------
// sgre_grad_if
// Valid/ready channel carrying one gradient result per request.
// ----------------------------------------------------------------------------
interface sgre_grad_if import sgre_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic                     run_last;

  modport source (output valid, output grad_x, output grad_y, output out_row,
                  output out_col, output run_last, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input out_row,
                  input out_col, input run_last, output ready);
endinterface

// File: src/sgre_line_store.sv
// ----------------------------------------------------------------------------
// sgre_line_store
// Two line memories holding the previous two rows, with registered reads.
// ----------------------------------------------------------------------------
`include "sobel_gradient_replicate_edge_top_assert.svh"

module sgre_line_store import sgre_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  pix_t          wr_pixel,
  input  logic          adv,
  input  logic [AW-1:0] adv_addr,
  output pix_t          older,
  output pix_t          newer
);

  pix_t older_mem [MAX_WIDTH];
  pix_t newer_mem [MAX_WIDTH];
  pix_t older_rd;
  pix_t newer_rd;
  pix_t wr_data;
  logic byp;

  // The newer row is written on the read cycle itself; the older row is
  // written when the item leaves, so a single-column frame needs a bypass.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_rd           <= older_mem[rd_addr];
      newer_rd           <= newer_mem[rd_addr];
      newer_mem[rd_addr] <= wr_pixel;
      byp                <= adv && (adv_addr == rd_addr);
    end
    if (adv) begin
      older_mem[adv_addr] <= newer;
      wr_data             <= newer;
    end
  end

  assign newer = newer_rd;
  assign older = byp ? wr_data : older_rd;

  `SGRE_ASSERT_IMP(a_bypass_single_col, rd_en && adv && (adv_addr == rd_addr),
                   rd_addr == '0, "line store collision away from column zero")

endmodule

// File: src/sgre_window.sv
// ----------------------------------------------------------------------------
// sgre_window
// 3x3 window, result sequencer, gradient arithmetic and result register.
// ----------------------------------------------------------------------------
`include "sobel_gradient_replicate_edge_top_assert.svh"

module sgre_window import sgre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               b_valid,
  input  col_item_t          item,
  output logic               take,
  sgre_grad_if.source        dst
);

  trio_t win [3];
  pos_t  cpos;
  logic [3:0] mask;
  logic [3:0] sel;
  logic [3:0] new_mask;
  logic       emit;
  logic       b_adv;
  logic       pass1;
  logic       col_end;
  logic       is_last;
  logic       o_valid;
  trio_t      top_row;
  trio_t      mid_row;
  trio_t      bot_row;
  trio_t      tsel;
  trio_t      msel;
  trio_t      bsel;
  logic signed [GRAD_W:0] gx_sum;
  logic signed [GRAD_W:0] gy_sum;
  logic signed [GRAD_W-1:0] gx_q;
  logic signed [GRAD_W-1:0] gy_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             last_q;

  function automatic trio_t col_pick(trio_t t, logic lst, logic ge1, logic ge2);
    trio_t o;
    o[0] = lst ? (ge1 ? t[1] : t[2]) : (ge2 ? t[0] : t[1]);
    o[1] = lst ? t[2] : t[1];
    o[2] = t[2];
    return o;
  endfunction

  function automatic logic signed [GRAD_W:0] quarter(pix_t p);
    return $signed((GRAD_W+1)'(p >> 2));
  endfunction

  function automatic logic signed [GRAD_W:0] half(pix_t p);
    return $signed((GRAD_W+1)'(p >> 1));
  endfunction

  // Results in order: previous row at previous column, previous row at last
  // column, then the same two for the current row when it is the last row.
  always_comb begin
    new_mask[0] = item.pos.row_ge1 & item.pos.col_ge1;
    new_mask[1] = item.pos.row_ge1 & item.pos.col_last;
    new_mask[2] = item.pos.row_last & item.pos.col_ge1;
    new_mask[3] = item.pos.row_last & item.pos.col_last;
  end

  assign sel     = mask & (~mask + 4'd1);
  assign pass1   = sel[2] | sel[3];
  assign col_end = sel[1] | sel[3];
  assign is_last = (mask & ~sel) == '0;
  assign emit    = (mask != '0) && (!o_valid || dst.ready);
  assign take    = (mask == '0) || (emit && is_last);
  assign b_adv   = b_valid && take;

  always_comb begin
    top_row = pass1 ? (cpos.row_ge1 ? win[1] : win[2])
                    : (cpos.row_ge2 ? win[0] : win[1]);
    mid_row = pass1 ? win[2] : win[1];
    bot_row = win[2];
    tsel = col_pick(top_row, col_end, cpos.col_ge1, cpos.col_ge2);
    msel = col_pick(mid_row, col_end, cpos.col_ge1, cpos.col_ge2);
    bsel = col_pick(bot_row, col_end, cpos.col_ge1, cpos.col_ge2);
    gx_sum = quarter(tsel[2]) - quarter(tsel[0]) + half(msel[2]) - half(msel[0])
           + quarter(bsel[2]) - quarter(bsel[0]);
    gy_sum = quarter(bsel[0]) + half(bsel[1]) + quarter(bsel[2])
           - quarter(tsel[0]) - half(tsel[1]) - quarter(tsel[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= '0;
      o_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (b_adv) begin
        mask <= new_mask;
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= item.older;
        win[1][2] <= item.newer;
        win[2][2] <= item.pixel;
      end else if (emit) begin
        mask <= mask & ~sel;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (dst.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      cpos <= item.pos;
    end
    if (emit) begin
      gx_q   <= GRAD_W'(gx_sum);
      gy_q   <= GRAD_W'(gy_sum);
      row_q  <= pass1 ? cpos.row : cpos.row - 1'b1;
      col_q  <= col_end ? cpos.col : cpos.col - 1'b1;
      last_q <= is_last;
    end
  end

  assign dst.valid    = o_valid;
  assign dst.grad_x   = gx_q;
  assign dst.grad_y   = gy_q;
  assign dst.out_row  = row_q;
  assign dst.out_col  = col_q;
  assign dst.run_last = last_q;

  `SGRE_ASSERT_NXT(a_mask_shrinks, (mask != '0) && emit && !b_adv,
                   $countones(mask) == $countones($past(mask)) - 1,
                   "pending results did not drop by one")
  `SGRE_ASSERT_IMP(a_mask_loaded, $rose(|mask), $past(b_valid),
                   "pending results appeared without a loaded column")

endmodule

// File: src/sobel_gradient_replicate_edge_top.sv
// ----------------------------------------------------------------------------
// sobel_gradient_replicate_edge_top
// Streaming 3x3 Sobel gradients with replicated borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and results for row r-1 leave while row r
// arrives; the last row of a frame also gives its own results. Unless the
// output stalls, a pixel that yields at most one result is taken every clock
// and the single result register delivers one result per cycle; a pixel
// that yields more (two at the end of a row, up to four at the end of the
// frame) holds the input until its last result is registered. A pixel
// reaches its first result via line memory read, window load and result
// register. The two line memories hold MAX_WIDTH pixels each and need no
// clearing after reset. Writing either register restarts the frame.
`include "sobel_gradient_replicate_edge_top_assert.svh"

module sobel_gradient_replicate_edge_top import sgre_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sgre_pixel_if.sink           pix_in,
  sgre_grad_if.source          grad_out
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    col_count;
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;
  logic [ROW_W-1:0] r_eff;
  logic [CW-1:0]    c_eff;
  pos_t             pos_next;
  logic             accept;
  logic             take;
  logic             b_valid;
  pix_t             b_pixel;
  logic [CW-1:0]    b_col;
  pos_t             b_pos;
  pix_t             older;
  pix_t             newer;
  col_item_t        item;

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (32'(frame_height) > 32'(ROW_LIMIT)) begin
      h_last = ROW_W'(ROW_LIMIT - 1);
    end else begin
      h_last = ROW_W'(frame_height - 1'b1);
    end
  end

  always_comb begin
    if ((row_count > h_last) || (col_count > w_last)) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row_count;
      c_eff = col_count;
    end
    pos_next.row      = r_eff;
    pos_next.col      = COL_W'(c_eff);
    pos_next.row_ge1  = r_eff != '0;
    pos_next.row_ge2  = r_eff > ROW_W'(1);
    pos_next.row_last = r_eff == h_last;
    pos_next.col_ge1  = c_eff != '0;
    pos_next.col_ge2  = 32'(c_eff) > 32'(1);
    pos_next.col_last = c_eff == w_last;
  end

  assign pix_in.ready = !b_valid || take;
  assign accept       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      row_count    <= '0;
      col_count    <= '0;
      b_valid      <= 1'b0;
    end else begin
      priority if (cfg_write && (cfg_index == REG_FRAME_WIDTH)) begin
        frame_width <= cfg_data[FW_W-1:0];
        row_count   <= '0;
        col_count   <= '0;
      end else if (cfg_write && (cfg_index == REG_FRAME_HEIGHT)) begin
        frame_height <= cfg_data[FH_W-1:0];
        row_count    <= '0;
        col_count    <= '0;
      end else if (accept) begin
        if (c_eff == w_last) begin
          col_count <= '0;
          row_count <= (r_eff == h_last) ? '0 : r_eff + 1'b1;
        end else begin
          col_count <= c_eff + 1'b1;
          row_count <= r_eff;
        end
      end else begin
        row_count <= row_count;
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (take) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pixel <= pix_in.pixel;
      b_col   <= c_eff;
      b_pos   <= pos_next;
    end
  end

  sgre_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (c_eff),
    .wr_pixel (pix_in.pixel),
    .adv      (b_valid && take),
    .adv_addr (b_col),
    .older    (older),
    .newer    (newer)
  );

  always_comb begin
    item.pixel = b_pixel;
    item.older = older;
    item.newer = newer;
    item.pos   = b_pos;
  end

  sgre_window u_window (
    .clk     (clk),
    .rst     (rst),
    .b_valid (b_valid),
    .item    (item),
    .take    (take),
    .dst     (grad_out)
  );

  `SGRE_ASSERT_IMP(a_counters_in_frame, 1'b1,
                   (col_count <= w_last) && (row_count <= h_last),
                   "pixel position outside the configured frame")

endmodule
